>>> rtl/touch_affine_map_and_grid_classify_defines.svh
// Assertion macros shared by the touch mapper RTL.
`ifndef TOUCH_AFFINE_MAP_AND_GRID_CLASSIFY_DEFINES_SVH
`define TOUCH_AFFINE_MAP_AND_GRID_CLASSIFY_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TAM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every clock edge, reset included.
`define TAM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/tamgc_pkg.sv
// Package with the shared types and constants of the touch mapper.
`default_nettype none
package tamgc_pkg;
  // Quotient width: the magnitude of the 51-bit signed sum fits in 50 bits.
  localparam int SumW = 50;
  localparam int DivW = 32;

  localparam logic [2:0] RegA = 3'd0;
  localparam logic [2:0] RegB = 3'd1;
  localparam logic [2:0] RegC = 3'd2;
  localparam logic [2:0] RegD = 3'd3;
  localparam logic [2:0] RegE = 3'd4;
  localparam logic [2:0] RegF = 3'd5;
  localparam logic [2:0] RegDiv = 3'd6;
  localparam logic [2:0] RegMode = 3'd7;

  localparam logic [1:0] ModeOff = 2'd0;
  localparam logic [1:0] ModePoint = 2'd1;
  localparam logic [1:0] ModeGrid = 2'd2;

  localparam logic [1:0] StNoEvent = 2'd0;
  localparam logic [1:0] StPoint = 2'd1;
  localparam logic [1:0] StButton = 2'd2;
  localparam logic [1:0] StNone = 2'd3;

  // Control that travels with an item down the divider chain.
  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic       zero_div;
    logic       neg_x;
    logic       neg_y;
  } ctrl_t;

  // One stage of state for the restoring divider.
  typedef struct packed {
    logic [SumW-1:0] rem_x;
    logic [SumW-1:0] quo_x;
    logic [SumW-1:0] rem_y;
    logic [SumW-1:0] quo_y;
    logic [DivW-1:0] dvs;
  } div_t;
endpackage
`default_nettype wire

>>> rtl/tamgc_div_cell.sv
// One cell of the divider chain: one quotient bit per coordinate.
`default_nettype none
module tamgc_div_cell #(
  parameter int BitPos = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  tamgc_pkg::ctrl_t     ctrl_in,
  input  tamgc_pkg::div_t      data_in,
  output tamgc_pkg::ctrl_t     ctrl_out,
  output tamgc_pkg::div_t      data_out
);
  localparam int W = tamgc_pkg::SumW;
  tamgc_pkg::div_t data_next;
  logic [W:0] trial_x;
  logic [W:0] trial_y;
  logic [W:0] dvs_ext;

  // Shift in one dividend bit and try to subtract the divisor.
  always_comb begin
    data_next = data_in;
    dvs_ext = {{(W + 1 - tamgc_pkg::DivW){1'b0}}, data_in.dvs};
    trial_x = {data_in.rem_x, data_in.quo_x[BitPos]} - dvs_ext;
    trial_y = {data_in.rem_y, data_in.quo_y[BitPos]} - dvs_ext;
    if (!trial_x[W]) begin
      data_next.rem_x = trial_x[W-1:0];
      data_next.quo_x[BitPos] = 1'b1;
    end else begin
      data_next.rem_x = {data_in.rem_x[W-2:0], data_in.quo_x[BitPos]};
      data_next.quo_x[BitPos] = 1'b0;
    end
    if (!trial_y[W]) begin
      data_next.rem_y = trial_y[W-1:0];
      data_next.quo_y[BitPos] = 1'b1;
    end else begin
      data_next.rem_y = {data_in.rem_y[W-2:0], data_in.quo_y[BitPos]};
      data_next.quo_y[BitPos] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl_out.mode <= ctrl_in.mode;
      ctrl_out.zero_div <= ctrl_in.zero_div;
      ctrl_out.neg_x <= ctrl_in.neg_x;
      ctrl_out.neg_y <= ctrl_in.neg_y;
      data_out <= data_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/tamgc_classify.sv
// Output stage: sign fix, saturation and grid sorting.
`default_nettype none
module tamgc_classify #(
  parameter int ScreenWidth = 320,
  parameter int ScreenHeight = 240
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  tamgc_pkg::ctrl_t                  ctrl_in,
  input  wire logic [tamgc_pkg::SumW-1:0]   quo_x,
  input  wire logic [tamgc_pkg::SumW-1:0]   quo_y,
  output logic                              valid,
  output logic [1:0]                        status,
  output logic [3:0]                        button_index,
  output logic signed [15:0]                pixel_x,
  output logic signed [15:0]                pixel_y
);
  localparam int W = tamgc_pkg::SumW;
  localparam int MW = ScreenWidth * 3 / 100;
  localparam int MH = ScreenHeight * 3 / 100;
  localparam int W1 = ScreenWidth / 3;
  localparam int W2 = (2 * ScreenWidth) / 3;
  localparam int H1 = ScreenHeight / 3;
  localparam int H2 = (2 * ScreenHeight) / 3;

  logic signed [W:0] px;
  logic signed [W:0] py;
  logic [1:0] col;
  logic [1:0] row;
  logic col_ok;
  logic row_ok;
  logic [1:0] status_next;
  logic [3:0] index_next;
  logic signed [15:0] sx;
  logic signed [15:0] sy;

  function automatic logic signed [15:0] sat16(input logic signed [W:0] v);
    if (v > $signed((W+1)'(32767))) begin
      sat16 = 16'sh7fff;
    end else if (v < -$signed((W+1)'(32768))) begin
      sat16 = -16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  always_comb begin
    px = ctrl_in.neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    py = ctrl_in.neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
    sx = sat16(px);
    sy = sat16(py);
    // Column and row decisions with dead-zone margins.
    col_ok = 1'b1;
    col = 2'd0;
    if (px < $signed((W+1)'(W1 - MW))) begin
      col = 2'd0;
    end else if (px > $signed((W+1)'(W1 + MW)) && px < $signed((W+1)'(W2 - MW))) begin
      col = 2'd1;
    end else if (px > $signed((W+1)'(W2 + MW))) begin
      col = 2'd2;
    end else begin
      col_ok = 1'b0;
    end
    row_ok = 1'b1;
    row = 2'd0;
    if (py < $signed((W+1)'(H1 - MH))) begin
      row = 2'd0;
    end else if (py > $signed((W+1)'(H1 + MH)) && py < $signed((W+1)'(H2 - MH))) begin
      row = 2'd1;
    end else if (py > $signed((W+1)'(H2 + MH))) begin
      row = 2'd2;
    end else begin
      row_ok = 1'b0;
    end
    status_next = tamgc_pkg::StPoint;
    index_next = 4'd0;
    if (ctrl_in.mode == tamgc_pkg::ModeOff) begin
      status_next = tamgc_pkg::StNoEvent;
      sx = '0;
      sy = '0;
    end else if (ctrl_in.zero_div) begin
      status_next = tamgc_pkg::StNone;
      sx = '0;
      sy = '0;
    end else if (ctrl_in.mode == tamgc_pkg::ModeGrid) begin
      if (col_ok && row_ok) begin
        status_next = tamgc_pkg::StButton;
        index_next = 4'({2'b00, row} * 4'd3 + {2'b00, col});
      end else begin
        status_next = tamgc_pkg::StNone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctrl_in.valid;
    end
    if (en) begin
      status <= status_next;
      button_index <= index_next;
      pixel_x <= sx;
      pixel_y <= sy;
    end
  end
endmodule
`default_nettype wire

>>> rtl/touch_affine_map_and_grid_classify.sv
// Top level of the touch affine mapper and grid classifier.
// Usage: raw samples enter on s_axis (tdata = raw_x, raw_y) and one result
// per sample leaves on m_axis (tdata = status, button_index, pixel_x,
// pixel_y). Configuration is written through cfg_we/cfg_index/cfg_data
// while no sample is in flight; index 0..7 selects coef_a..touch_mode.
// Pipeline: one register stage for the products, one for the sums, one per
// quotient bit in a chain of 50 divider cells, then one output register:
// 53 stages. Throughput: one sample per cycle unless the receiver stalls;
// every divider cell holds one sample, so the chain itself sets the
// latency and not the rate.
// Reset clears every valid flag and loads the register reset values.
// When the receiver stalls the whole pipeline holds; s_axis_tready is low
// while the output register is full and not being taken, even when the
// stages upstream are empty, and rises again with that output transfer.
// Coefficient products are 32x17 bits, one per multiplier per coordinate.
// Division is restoring, one bit per cell, on magnitudes with the sign
// restored at the output.
`default_nettype none
`include "touch_affine_map_and_grid_classify_defines.svh"
module touch_affine_map_and_grid_classify #(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // raw_x[15:0], raw_y[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // status[1:0], button_index[5:2],
                                          // pixel_x[21:6], pixel_y[37:22]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int W = tamgc_pkg::SumW;
  localparam int N = tamgc_pkg::SumW;

  logic signed [31:0] coef_a, coef_b, coef_c, coef_d, coef_e, coef_f;
  logic signed [31:0] common_divisor;
  logic [1:0] touch_mode;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= 32'sd1;
      coef_b <= '0;
      coef_c <= '0;
      coef_d <= '0;
      coef_e <= 32'sd1;
      coef_f <= '0;
      common_divisor <= 32'sd1;
      touch_mode <= tamgc_pkg::ModePoint;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tamgc_pkg::RegA: coef_a <= cfg_data;
        tamgc_pkg::RegB: coef_b <= cfg_data;
        tamgc_pkg::RegC: coef_c <= cfg_data;
        tamgc_pkg::RegD: coef_d <= cfg_data;
        tamgc_pkg::RegE: coef_e <= cfg_data;
        tamgc_pkg::RegF: coef_f <= cfg_data;
        tamgc_pkg::RegDiv: common_divisor <= cfg_data;
        tamgc_pkg::RegMode: touch_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid;
  assign en = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: four products.
  logic v1;
  logic signed [48:0] pa, pb, pd, pe;
  logic signed [16:0] rx, ry;
  assign rx = $signed({1'b0, s_axis_tdata[15:0]});
  assign ry = $signed({1'b0, s_axis_tdata[31:16]});
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
    if (en) begin
      pa <= 49'(coef_a) * 49'(rx);
      pb <= 49'(coef_b) * 49'(ry);
      pd <= 49'(coef_d) * 49'(rx);
      pe <= 49'(coef_e) * 49'(ry);
    end
  end

  // Stage 2: sums, signs and magnitudes.
  logic signed [W:0] sx_full, sy_full;
  logic [W-1:0] mag_x, mag_y;
  logic dneg;
  logic [31:0] dmag;
  assign sx_full = (W+1)'(pa) + (W+1)'(pb) + (W+1)'(coef_c);
  assign sy_full = (W+1)'(pd) + (W+1)'(pe) + (W+1)'(coef_f);
  assign dneg = common_divisor[31];
  assign dmag = dneg ? 32'(-common_divisor) : common_divisor;
  assign mag_x = sx_full[W] ? W'(-sx_full) : W'(sx_full);
  assign mag_y = sy_full[W] ? W'(-sy_full) : W'(sy_full);

  tamgc_pkg::ctrl_t ctrl [N+1];
  tamgc_pkg::div_t  data [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl[0].valid <= 1'b0;
    end else if (en) begin
      ctrl[0].valid <= v1;
    end
    if (en) begin
      ctrl[0].mode <= touch_mode;
      ctrl[0].zero_div <= (common_divisor == 32'sd0);
      ctrl[0].neg_x <= sx_full[W] ^ dneg;
      ctrl[0].neg_y <= sy_full[W] ^ dneg;
      data[0].rem_x <= '0;
      data[0].quo_x <= mag_x;
      data[0].rem_y <= '0;
      data[0].quo_y <= mag_y;
      data[0].dvs <= dmag;
    end
  end

  // Divider chain, most significant quotient bit first.
  for (genvar i = 0; i < N; i++) begin : g_cell
    tamgc_div_cell #(.BitPos(N - 1 - i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctrl_in(ctrl[i]), .data_in(data[i]),
      .ctrl_out(ctrl[i+1]), .data_out(data[i+1])
    );
  end

  logic [1:0] status;
  logic [3:0] button_index;
  logic signed [15:0] pixel_x, pixel_y;

  tamgc_classify #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT)) u_classify (
    .clk(clk), .rst(rst), .en(en),
    .ctrl_in(ctrl[N]), .quo_x(data[N].quo_x), .quo_y(data[N].quo_y),
    .valid(out_valid), .status(status), .button_index(button_index),
    .pixel_x(pixel_x), .pixel_y(pixel_y)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {2'b00, pixel_y, pixel_x, button_index, status};

  `TAM_ASSERT(a_stall_ready, clk, rst, (out_valid && !m_axis_tready) |-> !s_axis_tready, "ready while output stalled")
  `TAM_ASSERT(a_button_status, clk, rst, (m_axis_tvalid && status != tamgc_pkg::StButton) |-> (button_index == 4'd0), "button index without hit")
  `TAM_ASSERT(a_button_range, clk, rst, m_axis_tvalid |-> (button_index <= 4'd8), "button index out of range")
  `TAM_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !m_axis_tvalid, "output valid after reset")
endmodule
`default_nettype wire

>>> tb/touch_map_checker.sv
// Checker that predicts and compares every mapped touch result.
module touch_map_checker #(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Fields from the most significant end down, so status sits in bits 1:0.
  typedef struct packed {
    logic [15:0] py;
    logic [15:0] px;
    logic [3:0]  button;
    logic [1:0]  status;
  } touch_result_t;

  // Local copy of the calibration registers.
  logic signed [31:0] cal_a, cal_b, cal_c, cal_d, cal_e, cal_f, cal_div;
  logic [1:0] cal_mode;
  touch_result_t results_due[$];

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Cell 0..2 of one grid axis, or -1 inside a dead zone.
  function automatic int axis_cell(longint p, longint span);
    longint m, t1, t2;
    m = span * 3 / 100;
    t1 = span / 3;
    t2 = (2 * span) / 3;
    if (p < t1 - m) return 0;
    if (p > t1 + m && p < t2 - m) return 1;
    if (p > t2 + m) return 2;
    return -1;
  endfunction

  function automatic touch_result_t map_sample(logic [15:0] rx, logic [15:0] ry);
    touch_result_t r;
    longint x, y, mx, my, dv;
    int col, row;
    r = '0;
    x = longint'(rx);
    y = longint'(ry);
    if (cal_mode == tamgc_pkg::ModeOff) return r;
    if (cal_div == 0) begin
      r.status = tamgc_pkg::StNone;
      return r;
    end
    dv = longint'(cal_div);
    mx = (longint'(cal_a) * x + longint'(cal_b) * y + longint'(cal_c)) / dv;
    my = (longint'(cal_d) * x + longint'(cal_e) * y + longint'(cal_f)) / dv;
    r.px = clamp16(mx);
    r.py = clamp16(my);
    if (cal_mode != tamgc_pkg::ModeGrid) begin
      r.status = tamgc_pkg::StPoint;
      return r;
    end
    col = axis_cell(mx, SCREEN_WIDTH);
    row = axis_cell(my, SCREEN_HEIGHT);
    if (col < 0 || row < 0) begin
      r.status = tamgc_pkg::StNone;
    end else begin
      r.status = tamgc_pkg::StButton;
      r.button = 4'(row * 3 + col);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Track writes, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    touch_result_t got, want;
    if (rst) begin
      cal_a <= 1; cal_b <= 0; cal_c <= 0; cal_d <= 0; cal_e <= 1; cal_f <= 0;
      cal_div <= 1;
      cal_mode <= tamgc_pkg::ModePoint;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tamgc_pkg::RegA: cal_a <= cfg_data;
          tamgc_pkg::RegB: cal_b <= cfg_data;
          tamgc_pkg::RegC: cal_c <= cfg_data;
          tamgc_pkg::RegD: cal_d <= cfg_data;
          tamgc_pkg::RegE: cal_e <= cfg_data;
          tamgc_pkg::RegF: cal_f <= cfg_data;
          tamgc_pkg::RegDiv: cal_div <= cfg_data;
          tamgc_pkg::RegMode: cal_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(map_sample(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[37:0];
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", got[31:0], '0);
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.button != want.button) report_mismatch("button_index", got.button, want.button);
          if (got.px != want.px) report_mismatch("pixel_x", got.px, want.px);
          if (got.py != want.py) report_mismatch("pixel_y", got.py, want.py);
        end
      end
    end
    pending = results_due.size();
  end
endmodule

>>> tb/tb_touch_affine_map_and_grid_classify.sv
// Top of the touch mapper testbench: stimulus, calibration phases and verdict.
module tb_touch_affine_map_and_grid_classify;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 53;
  localparam int StallLimit = 2000;
  // Mode value three behaves as point mode.
  localparam logic [1:0] ModeAltPoint = 2'd3;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [39:0] m_axis_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending, quiet_cycles;
  bit hold_ready;

  touch_affine_map_and_grid_classify dut (.*);
  touch_map_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog on cycles with no transfer on either side.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall before each result, sometimes none.
  initial begin
    int gap;
    m_axis_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      gap = hold_ready ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
        m_axis_tready <= 0;
        @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk iff m_axis_tvalid);
    end
  end

  // One register write, after which cfg_we drops and the bus is left idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic set_calibration(int a, int b, int c, int d, int e, int f, int dv,
                                 logic [1:0] mode);
    write_reg(tamgc_pkg::RegA, a); write_reg(tamgc_pkg::RegB, b);
    write_reg(tamgc_pkg::RegC, c); write_reg(tamgc_pkg::RegD, d);
    write_reg(tamgc_pkg::RegE, e); write_reg(tamgc_pkg::RegF, f);
    write_reg(tamgc_pkg::RegDiv, dv); write_reg(tamgc_pkg::RegMode, {30'd0, mode});
  endtask

  // One sample transfer, after a random gap when gaps is set.
  task automatic send_sample(logic [15:0] rx, logic [15:0] ry, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if (gaps && $urandom_range(0, 2) == 0) gap = 0;
    repeat (gap) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {ry, rx};
    @(posedge clk iff s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  initial begin
    logic [1:0] mode;
    int dv;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    hold_ready = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset values: identity point mapping, extremes of the coordinates.
    send_sample(16'h0000, 16'h0000, 0);
    send_sample(16'hFFFF, 16'hFFFF, 0);
    send_sample(16'h7FFF, 16'h8000, 1);
    send_sample(16'h0123, 16'hABCD, 1);
    drain();

    // Grid mode with identity: cells, dead zones and grid line edges.
    set_calibration(1, 0, 0, 0, 1, 0, 1, tamgc_pkg::ModeGrid);
    send_sample(16'd10, 16'd10, 0);
    send_sample(16'd160, 16'd120, 0);
    send_sample(16'd300, 16'd230, 0);
    send_sample(16'd106, 16'd50, 0);
    send_sample(16'd97, 16'd50, 0);
    send_sample(16'd96, 16'd73, 0);
    send_sample(16'd117, 16'd87, 0);
    send_sample(16'd50, 16'd200, 1);
    drain();

    // Negative mapping with extreme coefficients in grid mode.
    set_calibration(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF, -7, tamgc_pkg::ModeGrid);
    send_sample(16'hFFFF, 16'h0000, 0);
    send_sample(16'h0000, 16'hFFFF, 0);
    send_sample(16'h0003, 16'h0001, 0);
    drain();

    // Zero divisor, disabled mode and mode value three.
    write_reg(tamgc_pkg::RegDiv, 0);
    send_sample(16'h1234, 16'h5678, 0);
    drain();
    write_reg(tamgc_pkg::RegMode, tamgc_pkg::ModeOff);
    write_reg(tamgc_pkg::RegDiv, 3);
    send_sample(16'h1234, 16'h5678, 0);
    drain();
    write_reg(tamgc_pkg::RegMode, ModeAltPoint);
    send_sample(16'h4321, 16'h8765, 0);
    drain();

    // Random phases with varied calibrations, mostly grid and point mode.
    for (int phase = 0; phase < 40; phase++) begin
      mode = $urandom_range(0, 9) < 5 ? tamgc_pkg::ModeGrid : $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: dv = 0;
        1: dv = pick_coef();
        default: dv = $urandom_range(1, 300) * ($urandom_range(0, 1) ? 1 : -1);
      endcase
      if ($urandom_range(0, 1))
        set_calibration($urandom_range(0, 40) * dv / 8, pick_coef() / 64, pick_coef(),
                        pick_coef() / 64, $urandom_range(0, 40) * dv / 8, pick_coef(),
                        dv, mode);
      else
        set_calibration(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                        pick_coef(), pick_coef(), dv, mode);
      hold_ready = (phase % 5 == 4);
      for (int k = 0; k < 50; k++)
        send_sample(pick_coord(), pick_coord(), (phase % 5) != 4);
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
